@@ rtl/assert_macros.svh @@
// Assertion macros, included by square_coin_ways_counter.sv.
// The macros assume a clock named clk and an active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every clock edge outside reset.
`define SCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that expr holds in the cycle after cond.
`define SCW_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define SCW_ASSERT(lbl, prop, msg)
`define SCW_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

@@ rtl/scw_pkg.sv @@
`default_nettype none
package scw_pkg;

  localparam int MAX_AMOUNT = 1023;
  localparam int AMOUNT_W   = 10;
  localparam int WAYS_W     = 64;
  localparam int ADDR_W     = (MAX_AMOUNT > 1) ? $clog2(MAX_AMOUNT + 1) : 1;
  localparam int DEPTH      = MAX_AMOUNT + 1;
  // square value and its root, wide enough for the first square past the amount
  localparam int SQ_W       = ADDR_W + 2;
  localparam int ROOT_W     = SQ_W - 1;
  localparam int CMP_W      = (ADDR_W > AMOUNT_W) ? ADDR_W : AMOUNT_W;

  typedef struct packed {
    logic              sat;
    logic [WAYS_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_INIT  = 7'b0000010,
    ST_GAP   = 7'b0000100,
    ST_PASS  = 7'b0001000,
    ST_STEP  = 7'b0010000,
    ST_FETCH = 7'b0100000,
    ST_LAST  = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

@@ rtl/scw_ram.sv @@
`default_nettype none
module scw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/square_coin_ways_counter.sv @@
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------
// in      | in_valid, in_stall  | amount [9:0]
// out     | out_valid, out_stall| ways [63:0], saturated
//
// One item at a time: in_stall is high from acceptance until the result
// moves into the output register. For a clamped amount n an item first
// fills entries 0..n, then sweeps each square coin s=4,9,..<=n over
// entries s..n, then reads entry n into the output register; the block
// returns to idle before it takes the next item. The single table write
// port sets the pace, one table update per cycle.
// rst is synchronous and clears the sequencer and out_valid; the table
// holds no reset value, since every item rewrites entries 0..n first.
// A stalled result waits in the output register; the next item is accepted
// meanwhile and parks in the final read state until the register frees up.
`default_nettype none
`include "assert_macros.svh"
module square_coin_ways_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [scw_pkg::AMOUNT_W-1:0]  amount,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scw_pkg::WAYS_W-1:0]    ways,
  output logic                          saturated
);

  import scw_pkg::*;

  state_t              state;
  logic [ADDR_W-1:0]   n;       // clamped amount of the current item
  logic [ADDR_W-1:0]   p;       // table index being swept
  logic [SQ_W-1:0]     s;       // current square coin
  logic [ROOT_W-1:0]   k;       // its root
  logic                pend;    // read data of pend_addr arrives this cycle
  logic [ADDR_W-1:0]   pend_addr;

  logic [ADDR_W-1:0]   raddr_a;
  logic [ADDR_W-1:0]   raddr_b;
  logic [ENTRY_W-1:0]  rdata_a;
  logic [ENTRY_W-1:0]  rdata_b;
  entry_t              qa;
  entry_t              qb;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  entry_t              wentry;
  entry_t              sum_entry;
  logic [WAYS_W:0]     sum_wide;
  logic [CMP_W-1:0]    amt_ext;
  logic [ADDR_W-1:0]   n_in;
  logic                in_take;
  logic                out_free;
  logic                s_fits;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Clamp the amount to the table size.
  assign amt_ext = CMP_W'(amount);
  assign n_in    = (amt_ext > CMP_W'(MAX_AMOUNT)) ? ADDR_W'(MAX_AMOUNT) : ADDR_W'(amt_ext);

  assign s_fits = (s <= SQ_W'(n));

  // Two copies of the table, written together, give two reads per cycle:
  // port a reads ways[p], port b reads ways[p - s].
  always_comb begin
    raddr_a = p;
    raddr_b = p - s[ADDR_W-1:0];
    if (state == ST_FETCH || state == ST_LAST) begin
      raddr_a = n;   // hold the final entry on the read port while waiting
    end
  end

  assign qa = entry_t'(rdata_a);
  assign qb = entry_t'(rdata_b);

  // Saturating add; saturation is sticky through the addends.
  always_comb begin
    sum_wide = {1'b0, qa.cnt} + {1'b0, qb.cnt};
    sum_entry.sat = qa.sat | qb.sat | sum_wide[WAYS_W];
    sum_entry.cnt = sum_wide[WAYS_W] ? {WAYS_W{1'b1}} : sum_wide[WAYS_W-1:0];
  end

  // Init writes the 1-coin count; otherwise write back the pending sum.
  always_comb begin
    we    = pend || (state == ST_INIT);
    waddr = pend ? pend_addr : p;
    if (pend) begin
      wentry = sum_entry;
    end else begin
      wentry.sat = 1'b0;
      wentry.cnt = WAYS_W'(1);
    end
  end

  scw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  scw_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      pend <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            n     <= n_in;
            p     <= '0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          // fill entries 0..n with one way each
          if (p == n) begin
            k     <= ROOT_W'(2);
            s     <= SQ_W'(4);
            state <= ST_GAP;
          end else begin
            p <= p + ADDR_W'(1);
          end
        end
        ST_GAP: begin
          // last write of the previous sweep has landed; pick the next coin
          if (s_fits) begin
            p     <= s[ADDR_W-1:0];
            state <= ST_PASS;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_PASS: begin
          pend      <= 1'b1;
          pend_addr <= p;
          if (p == n) begin
            state <= ST_STEP;
          end else begin
            p <= p + ADDR_W'(1);
          end
        end
        ST_STEP: begin
          // drain the final write; advance to the next square
          s     <= s + SQ_W'({k, 1'b1});
          k     <= k + ROOT_W'(1);
          state <= ST_GAP;
        end
        ST_FETCH: begin
          state <= ST_LAST;
        end
        ST_LAST: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LAST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LAST && out_free) begin
      ways      <= qa.cnt;
      saturated <= qa.sat;
    end
  end

  // During a sweep, the write-back never hits an entry being read in the same cycle.
  `SCW_ASSERT(a_no_rw_hazard, !(pend && state == ST_PASS) || (pend_addr != raddr_a && pend_addr != raddr_b), "read collides with pending write")
  // A sweep only runs with a coin that fits and an index at or above it.
  `SCW_ASSERT(a_sweep_bounds, state != ST_PASS || (s_fits && SQ_W'(p) >= s), "sweep out of bounds")
  // A result appears only from the final read.
  `SCW_ASSERT(a_out_source, !$rose(out_valid) || $past(state == ST_LAST), "result without final read")
  // A saturated count is clamped to all ones.
  `SCW_ASSERT(a_sat_clamped, !(out_valid && saturated) || (&ways), "saturated count not clamped")
  // A pending write is only created by a sweep cycle.
  `SCW_ASSERT_NEXT(a_pend_origin, state != ST_PASS, !pend, "pending write outside sweep")

endmodule
`default_nettype wire

@@ tb/tb_square_coin_ways_counter.sv @@
`default_nettype none
module tb_square_coin_ways_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import scw_pkg::*;

  // Give up after this many cycles in which neither channel moves an item.
  // The limit outlasts the processing of the largest amount, the longest item.
  localparam int QUIET_LIMIT = 120000;
  // Cycles the receiver refuses results while the sender keeps offering.
  localparam int HOLD_OFF_CYCLES = 600;

  typedef struct {
    logic [WAYS_W-1:0] ways;
    logic              sat;
  } ways_result_t;

  // Predict the ways count of each accepted amount and match results
  // against the predictions in arrival order.
  class coin_ways_board;
    logic [WAYS_W-1:0] partial_ways [MAX_AMOUNT+1];
    logic              partial_sat  [MAX_AMOUNT+1];
    ways_result_t      pending_counts [$];
    int unsigned       errors;

    function new();
      errors = 0;
      foreach (partial_ways[p]) begin
        partial_ways[p] = '0;
        partial_sat[p]  = 1'b0;
      end
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Rebuild the ways table up to the amount, one square coin at a time.
    function ways_result_t count_square_ways(logic [AMOUNT_W-1:0] amt);
      int                n;
      logic [WAYS_W:0]   sum;
      logic              sat;
      ways_result_t      res;
      n = amt;
      if (n > MAX_AMOUNT) n = MAX_AMOUNT;
      for (int p = 0; p <= n; p++) begin
        partial_ways[p] = 1;
        partial_sat[p]  = 1'b0;
      end
      for (int k = 2; k * k <= n; k++) begin
        for (int p = k * k; p <= n; p++) begin
          sum = {1'b0, partial_ways[p]} + {1'b0, partial_ways[p - k * k]};
          sat = partial_sat[p] | partial_sat[p - k * k];
          if (sum[WAYS_W]) begin
            sum = {1'b0, {WAYS_W{1'b1}}};
            sat = 1'b1;
          end
          partial_ways[p] = sum[WAYS_W-1:0];
          partial_sat[p]  = sat;
        end
      end
      res.ways = partial_ways[n];
      res.sat  = partial_sat[n];
      return res;
    endfunction

    function void note_amount(logic [AMOUNT_W-1:0] amt);
      pending_counts.push_back(count_square_ways(amt));
    endfunction

    task check_result(logic [WAYS_W-1:0] got_ways, logic got_sat);
      ways_result_t want;
      if (pending_counts.size() == 0) begin
        report($sformatf("result ways=%0d with no item pending", got_ways));
      end else begin
        want = pending_counts.pop_front();
        if (got_ways !== want.ways)
          report($sformatf("ways %0d, want %0d", got_ways, want.ways));
        if (got_sat !== want.sat)
          report($sformatf("saturated %b, want %b", got_sat, want.sat));
      end
    endtask

    function int pending();
      return pending_counts.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [AMOUNT_W-1:0] amount;
  logic                out_valid;
  logic                out_stall;
  logic [WAYS_W-1:0]   ways;
  logic                saturated;

  coin_ways_board board;

  // Idle odds in percent per cycle for each side, changed per phase.
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  // Set by the stimulus to ask the receiver for a long hold-off.
  int unsigned hold_request;

  // Edge cases first: zero, amounts at and next to some of the first
  // squares, alternating bit patterns, and the top of the range.
  int unsigned corner_amounts [$] = '{0, 1, 2, 3, 4, 5, 8, 9, 12, 13, 16, 17,
                                      24, 25, 36, 100, 341, 512, 682, 1022,
                                      1023};

  square_coin_ways_counter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .amount    (amount),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ways      (ways),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one amount, idling first at the current odds, and hold it
  // until the block takes it.
  task send_amount(logic [AMOUNT_W-1:0] amt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    amount   <= amt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_amount(amt);
  endtask

  // Mostly small amounts keep the run short; a few reach the top bits.
  function logic [AMOUNT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return AMOUNT_W'($urandom_range(63));
    if (r < 90) return AMOUNT_W'($urandom_range(255, 64));
    return AMOUNT_W'($urandom_range(MAX_AMOUNT, 256));
  endfunction

  // Receiver: check each accepted result, then pick the next stall value.
  // A requested hold-off is counted down here at each edge.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_result(ways, saturated);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    board           = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    amount          = '0;
    hold_request    = 0;
    sender_idle_pct = 29;
    recv_idle_pct   = 69;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the edge cases with a slow receiver.
    foreach (corner_amounts[i]) send_amount(AMOUNT_W'(corner_amounts[i]));

    // Swap the idle odds: slow sender, eager receiver.
    sender_idle_pct = 69;
    recv_idle_pct   = 29;
    repeat (40) send_amount(pick_amount());

    // No idling. Hold off the receiver while small amounts keep coming,
    // so the output register fills, one item parks and the input stalls.
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_request    = HOLD_OFF_CYCLES;
    repeat (10) send_amount(AMOUNT_W'($urandom_range(15)));
    repeat (30) send_amount(pick_amount());
    in_valid <= 1'b0;

    // Drain, then give the block a little time to show any extra result.
    while (board.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
